[hw/rtl/clist_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package clist_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int CMD_W     = 4;
   localparam int POS_W     = 7;
   localparam int LEN_W     = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 4'd0,
      CMD_REMOVE = 4'd1,
      CMD_GET    = 4'd2,
      CMD_START  = 4'd3,
      CMD_END    = 4'd4,
      CMD_PREV   = 4'd5,
      CMD_NEXT   = 4'd6,
      CMD_MOVE   = 4'd7,
      CMD_CLEAR  = 4'd8
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GRAB,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]  list_length;
      logic [LEN_W-1:0]  cursor_pos;
      logic              error;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/clist_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module clist_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hw/rtl/clist_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module clist_ctrl #(
   parameter int DEPTH = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [clist_pkg::CMD_W-1:0]  req_cmd,
   input  wire logic [clist_pkg::DATA_W-1:0] req_value,
   input  wire logic [clist_pkg::POS_W-1:0]  req_pos,
   output logic                              done_valid,
   input  wire logic                         done_take,
   output clist_pkg::rsp_type                done_rsp,
   output logic                              mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]          mem_wr_addr,
   output logic [clist_pkg::DATA_W-1:0]      mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]          mem_rd_addr,
   input  wire logic [clist_pkg::DATA_W-1:0] mem_rd_data
);

   import clist_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 2);
   localparam int XW = (CW > POS_W) ? CW : POS_W;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [AW-1:0]     src_ff, src_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic              pend_ff, pend_in;
   logic              up_ff, up_in;
   logic              rm_ff, rm_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] rd_ff, rd_in;
   logic              err_ff, err_in;

   cmd_type           cmd;
   logic [CW-1:0]     ceff;
   logic [CW-1:0]     slot_w;
   logic              no_entry;
   logic [XW-1:0]     pos_x;
   logic [XW-1:0]     count_x;
   logic [XW-1:0]     cursor_x;

   assign cmd      = cmd_type'(req_cmd);
   assign no_entry = (cursor_ff == '0) || (cursor_ff > count_ff);
   assign pos_x    = XW'(req_pos);
   assign count_x  = XW'(count_ff);
   assign cursor_x = XW'(cursor_ff);

   always_comb begin
      if (cursor_ff == '0) begin
         ceff = CW'(1);
      end else if (cursor_ff > count_ff + CW'(1)) begin
         ceff = count_ff + CW'(1);
      end else begin
         ceff = cursor_ff;
      end
      slot_w = ceff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cursor_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      src_ff       <= src_in;
      pend_addr_ff <= pend_addr_in;
      slot_ff      <= slot_in;
      up_ff        <= up_in;
      rm_ff        <= rm_in;
      val_ff       <= val_in;
      rd_ff        <= rd_in;
      err_ff       <= err_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      rem_in       = rem_ff;
      src_in       = src_ff;
      pend_addr_in = pend_addr_ff;
      slot_in      = slot_ff;
      pend_in      = pend_ff;
      up_in        = up_ff;
      rm_in        = rm_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      err_in       = err_ff;
      req_tready   = 1'b0;
      done_valid   = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = src_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               rd_in    = '0;
               err_in   = 1'b0;
               state_in = ST_DONE;
               case (cmd)
                  CMD_INSERT: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        err_in = 1'b1;
                     end else begin
                        slot_in  = AW'(slot_w);
                        src_in   = AW'(count_ff - CW'(1));
                        rem_in   = count_ff - slot_w;
                        up_in    = 1'b1;
                        pend_in  = 1'b0;
                        val_in   = req_value;
                        state_in = ST_SHIFT;
                     end
                  end
                  CMD_REMOVE, CMD_GET: begin
                     if (no_entry) begin
                        err_in = 1'b1;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = AW'(cursor_ff - CW'(1));
                        rm_in       = (cmd == CMD_REMOVE);
                        state_in    = ST_GRAB;
                     end
                  end
                  CMD_START: begin
                     cursor_in = CW'(1);
                  end
                  CMD_END: begin
                     cursor_in = count_ff;
                  end
                  CMD_PREV: begin
                     if (cursor_ff > CW'(1)) begin
                        cursor_in = cursor_ff - CW'(1);
                     end
                  end
                  CMD_NEXT: begin
                     if (cursor_ff < count_ff) begin
                        cursor_in = cursor_ff + CW'(1);
                     end
                  end
                  CMD_MOVE: begin
                     if (pos_x < count_x) begin
                        cursor_in = CW'(pos_x);
                     end
                  end
                  CMD_CLEAR: begin
                     count_in  = '0;
                     cursor_in = CW'(1);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GRAB: begin
            rd_in = mem_rd_data;
            if (!rm_ff) begin
               state_in = ST_DONE;
            end else begin
               // close the gap: entry i takes entry i+1 from the cursor up
               rem_in   = count_ff - cursor_ff;
               src_in   = AW'(cursor_ff);
               up_in    = 1'b0;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end else if (rem_ff == '0) begin
               state_in = ST_DONE;
               if (up_ff) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = slot_ff;
                  mem_wr_data = val_ff;
                  count_in    = count_ff + CW'(1);
                  cursor_in   = CW'(slot_ff) + CW'(2);
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            if (rem_ff != '0) begin
               mem_rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = up_ff ? src_ff + AW'(1) : src_ff - AW'(1);
               src_in       = up_ff ? src_ff - AW'(1) : src_ff + AW'(1);
               rem_in       = rem_ff - CW'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_DONE: begin
            done_valid = 1'b1;
            if (done_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign done_rsp.read_value  = rd_ff;
   assign done_rsp.list_length = count_x[LEN_W-1:0];
   assign done_rsp.cursor_pos  = cursor_x[LEN_W-1:0];
   assign done_rsp.error       = err_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("list count above depth");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_ff} <= {1'b0, count_ff} + (CW+1)'(1))
      else $error("cursor beyond end plus one");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
      else $error("read and write hit the same entry");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted word left engine idle");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (done_valid && !done_take) |=> (done_valid && $stable(done_rsp)))
      else $error("pending result changed");
`endif

endmodule

`default_nettype wire

[hw/rtl/cursor_list_engine.sv]
// Flow: a cursor move goes straight to the done state, get reads the entry first,
// insert shifts entries up, and remove reads the entry and then shifts entries down.
// Throughput: one command at a time; the shift moves one entry per cycle through the
// single read and single write port of the entry RAM.
// A response waits in an output register while the next command is taken.
// Reset: synchronous, active high; empties the list and clears the cursor to zero.
`timescale 1ns / 1ps
`default_nettype none

module cursor_list_engine #(
   parameter int DEPTH = clist_pkg::DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // write_value[31:0], position[38:32], pad
   input  wire logic [3:0]  req_tuser,   // command[3:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // read_value[31:0], list_length[38:32],
                                         // cursor_pos[45:39], pad
   output logic [0:0]       rsp_tuser    // error[0]
);

   import clist_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic              done_valid;
   logic              done_take;
   rsp_type           done_rsp;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [DATA_W-1:0] mem_rd_data;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   clist_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_cmd     (req_tuser),
      .req_value   (req_tdata[31:0]),
      .req_pos     (req_tdata[38:32]),
      .done_valid  (done_valid),
      .done_take   (done_take),
      .done_rsp    (done_rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   clist_mem #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign done_take = done_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (done_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_take) begin
         rsp_ff <= done_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.cursor_pos, rsp_ff.list_length, rsp_ff.read_value};
   assign rsp_tuser  = rsp_ff.error;

endmodule

`default_nettype wire
